// ===== sv/rm3sh_pkg.sv =====
package rm3sh_pkg;

  // Table geometry
  localparam int TABLE_CAPACITY = 1024;
  localparam int NODE_BITS      = 16;
  localparam int IDX_BITS       = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int COUNT_BITS     = $clog2(TABLE_CAPACITY + 1);

  // Port field widths
  localparam int OPERAND_BITS = 16;
  localparam int CFG_BITS     = 15;
  localparam int TOTAL_BITS   = 11;

  // Register file: one 32-bit register at byte address 0
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic [ADDR_BITS-3:0] REG_INPUT_COUNT = '0;

  // Result status codes
  typedef enum logic [1:0] {
    ST_TRIVIAL = 2'd0,
    ST_FOUND   = 2'd1,
    ST_CREATED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic [NODE_BITS-1:0] lo;
    logic [NODE_BITS-1:0] mid;
    logic [NODE_BITS-1:0] hi;
    logic                 found;
    logic                 created;
    logic [IDX_BITS-1:0]  index;
  } token_t;

endpackage

// ===== sv/rm3sh_cell.sv =====
module rm3sh_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rm3sh_pkg::IDX_BITS-1:0]   cell_index,
  input  logic [rm3sh_pkg::COUNT_BITS-1:0] gate_fill,
  input  rm3sh_pkg::token_t                tok_in,
  output rm3sh_pkg::token_t                tok_out
);
  import rm3sh_pkg::*;

  logic [NODE_BITS-1:0]  entry_lo;
  logic [NODE_BITS-1:0]  entry_mid;
  logic [NODE_BITS-1:0]  entry_hi;
  logic [COUNT_BITS-1:0] slot;
  logic                  pending;
  logic                  hit;
  logic                  append;
  token_t                tok_next;
  token_t                tok_data;
  logic                  tok_valid;

  // Compare against the stored gate, or claim this slot if it is the next free one
  assign slot    = COUNT_BITS'(cell_index);
  assign pending = tok_in.valid && !tok_in.found && !tok_in.created;
  assign hit     = pending && (slot < gate_fill) && (entry_lo == tok_in.lo) &&
                   (entry_mid == tok_in.mid) && (entry_hi == tok_in.hi);
  assign append  = pending && (slot == gate_fill);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.index = cell_index;
    end
    if (append) begin
      tok_next.created = 1'b1;
      tok_next.index   = cell_index;
    end
  end

  // Stored triple
  always_ff @(posedge clk) begin
    if (append) begin
      entry_lo  <= tok_in.lo;
      entry_mid <= tok_in.mid;
      entry_hi  <= tok_in.hi;
    end
  end

  // Token stage towards the next cell
  always_ff @(posedge clk) begin
    tok_data <= tok_next;
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_next.valid;
    end
  end

  always_comb begin
    tok_out       = tok_data;
    tok_out.valid = tok_valid;
  end

endmodule

// ===== sv/rm3sh_chain.sv =====
module rm3sh_chain (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rm3sh_pkg::COUNT_BITS-1:0] gate_fill,
  input  rm3sh_pkg::token_t                tok_in,
  output rm3sh_pkg::token_t                tok_out
);
  import rm3sh_pkg::*;

  token_t links [TABLE_CAPACITY+1];

  assign links[0] = tok_in;

  // Row of cells, one per table entry
  for (genvar g = 0; g < TABLE_CAPACITY; g++) begin : g_cell
    rm3sh_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_BITS'(g)),
      .gate_fill  (gate_fill),
      .tok_in     (links[g]),
      .tok_out    (links[g+1])
    );
  end

  assign tok_out = links[TABLE_CAPACITY];

endmodule

// ===== sv/rm3_structural_hash_table.sv =====
// Structural hashing table for RM3 gates. Each request carries operands x, y, z; the trivial
// rules (x==z gives x, x==y gives z, z==y gives x) are resolved in the check state. Any other
// request is sent as the key (min(x,z), y, max(x,z)) down a chain of TABLE_CAPACITY cells,
// one cell per cycle; each cell holds one stored gate and compares it, and the first free
// cell stores the key if no earlier cell matched. The result is captured in the check or
// search state and then loaded into the output register. One request is processed at a
// time; the next one is taken the cycle after the result is loaded, even while that result
// still waits in the output register. Gate ids are index + input_count + 2; a miss on a full
// table returns id 0 with status 3. input_count is written over the APB port at address 0.
module rm3_structural_hash_table (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rm3sh_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [rm3sh_pkg::DATA_BITS-1:0]    pwdata,
  output logic [rm3sh_pkg::DATA_BITS-1:0]    prdata,
  output logic                               pready,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rm3sh_pkg::OPERAND_BITS-1:0] operand_a,
  input  logic [rm3sh_pkg::OPERAND_BITS-1:0] operand_b,
  input  logic [rm3sh_pkg::OPERAND_BITS-1:0] operand_c,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rm3sh_pkg::OPERAND_BITS-1:0] node_id,
  output rm3sh_pkg::status_t                 status,
  output logic [rm3sh_pkg::TOTAL_BITS-1:0]   gate_total
);
  import rm3sh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                state;
  logic [CFG_BITS-1:0]   input_count;
  logic [COUNT_BITS-1:0] gate_fill;
  logic [COUNT_BITS-1:0] fill_next;
  logic [NODE_BITS-1:0]  op_x;
  logic [NODE_BITS-1:0]  op_y;
  logic [NODE_BITS-1:0]  op_z;
  logic [NODE_BITS-1:0]  res_node;
  status_t               res_status;
  logic [NODE_BITS-1:0]  trivial_node;
  logic                  trivial;
  logic [NODE_BITS-1:0]  tail_id;
  logic                  in_take;
  logic                  out_load;
  logic                  cfg_write;
  token_t                chain_in;
  token_t                chain_out;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[ADDR_BITS-1:2] == REG_INPUT_COUNT);
  assign prdata    = (paddr[ADDR_BITS-1:2] == REG_INPUT_COUNT) ?
                     DATA_BITS'(input_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count <= '0;
    end else if (cfg_write) begin
      input_count <= pwdata[CFG_BITS-1:0];
    end
  end

  // Request handshake
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_x <= NODE_BITS'(operand_a);
      op_y <= NODE_BITS'(operand_b);
      op_z <= NODE_BITS'(operand_c);
    end
  end

  // Trivial rules, in order
  always_comb begin
    trivial      = 1'b1;
    trivial_node = op_x;
    priority if (op_x == op_z) begin
      trivial_node = op_x;
    end else if (op_x == op_y) begin
      trivial_node = op_z;
    end else if (op_z == op_y) begin
      trivial_node = op_x;
    end else begin
      trivial = 1'b0;
    end
  end

  // Canonical key enters the cell chain
  always_comb begin
    chain_in         = '0;
    chain_in.valid   = (state == S_CHECK) && !trivial;
    chain_in.lo      = (op_x < op_z) ? op_x : op_z;
    chain_in.mid     = op_y;
    chain_in.hi      = (op_x < op_z) ? op_z : op_x;
  end

  rm3sh_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .gate_fill (gate_fill),
    .tok_in    (chain_in),
    .tok_out   (chain_out)
  );

  assign tail_id = NODE_BITS'(32'(chain_out.index) + 32'(input_count) + 32'd2);

  // Sequencer
  assign out_load  = (state == S_FINISH) && (!out_valid || !out_stall);
  assign fill_next = (res_status == ST_CREATED) ? gate_fill + COUNT_BITS'(1) : gate_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gate_fill <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= trivial ? S_FINISH : S_SEARCH;
        end
        S_SEARCH: begin
          if (chain_out.valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            gate_fill <= fill_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if ((state == S_CHECK) && trivial) begin
      res_node   <= trivial_node;
      res_status <= ST_TRIVIAL;
    end else if ((state == S_SEARCH) && chain_out.valid) begin
      priority if (chain_out.found) begin
        res_node   <= tail_id;
        res_status <= ST_FOUND;
      end else if (chain_out.created) begin
        res_node   <= tail_id;
        res_status <= ST_CREATED;
      end else begin
        res_node   <= '0;
        res_status <= ST_FULL;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      node_id    <= OPERAND_BITS'(res_node);
      status     <= res_status;
      gate_total <= TOTAL_BITS'(fill_next);
    end
  end

endmodule

// ===== sv/rm3sh_checker.sv =====
module rm3sh_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [rm3sh_pkg::ADDR_BITS-1:0]    paddr,
  input logic [rm3sh_pkg::DATA_BITS-1:0]    pwdata,
  input logic [rm3sh_pkg::DATA_BITS-1:0]    prdata,
  input logic                               pready,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [rm3sh_pkg::OPERAND_BITS-1:0] operand_a,
  input logic [rm3sh_pkg::OPERAND_BITS-1:0] operand_b,
  input logic [rm3sh_pkg::OPERAND_BITS-1:0] operand_c,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [rm3sh_pkg::OPERAND_BITS-1:0] node_id,
  input rm3sh_pkg::status_t                 status,
  input logic [rm3sh_pkg::TOTAL_BITS-1:0]   gate_total
);
  import rm3sh_pkg::*;

  // A full-table answer only comes with the table at capacity and id zero
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |->
      (gate_total == TOTAL_BITS'(TABLE_CAPACITY) && node_id == '0))
    else $error("full status without a full table");

  // A freshly created gate means the table holds at least one gate
  a_created_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_CREATED) |-> (gate_total != '0))
    else $error("created status with empty table");

  // One request at a time: busy straight after acceptance
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one in progress");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(node_id) && $stable(status) && $stable(gate_total)))
    else $error("stalled result changed");

endmodule

bind rm3_structural_hash_table rm3sh_checker u_checker (.*);

// ===== bench/rm3sh_result_checker.sv =====
`timescale 1ns / 100ps

module rm3sh_result_checker
  import rm3sh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_BITS-1:0]    paddr,
  input  logic [DATA_BITS-1:0]    pwdata,
  input  logic [DATA_BITS-1:0]    prdata,
  input  logic                    pready,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [OPERAND_BITS-1:0] operand_a,
  input  logic [OPERAND_BITS-1:0] operand_b,
  input  logic [OPERAND_BITS-1:0] operand_c,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [OPERAND_BITS-1:0] node_id,
  input  status_t                 status,
  input  logic [TOTAL_BITS-1:0]   gate_total,
  output int                      fail_count,
  output int                      pending
);

  typedef logic [NODE_BITS-1:0] node_t;

  typedef struct packed {
    logic [OPERAND_BITS-1:0] id;
    status_t                 st;
    logic [TOTAL_BITS-1:0]   total;
  } gate_answer_t;

  // Shadow of the gate store, kept as (min, y, max)
  node_t               key_lo  [TABLE_CAPACITY];
  node_t               key_mid [TABLE_CAPACITY];
  node_t               key_hi  [TABLE_CAPACITY];
  int                  gates_stored = 0;
  logic [CFG_BITS-1:0] input_count  = '0;
  gate_answer_t        answers_due[$];
  int                  mistakes     = 0;

  function automatic node_t gate_id(input int slot);
    return node_t'(slot + int'(input_count) + 2);
  endfunction

  // Looks the request up and updates the shadow store as the block would
  function automatic gate_answer_t resolve_gate(input node_t x, input node_t y, input node_t z);
    gate_answer_t ans;
    node_t        lo;
    node_t        hi;
    bit           hit;
    ans.st = ST_TRIVIAL;
    ans.id = '0;
    // trivial rules, in priority order
    if (x == z) begin
      ans.id = OPERAND_BITS'(x);
    end else if (x == y) begin
      ans.id = OPERAND_BITS'(z);
    end else if (z == y) begin
      ans.id = OPERAND_BITS'(x);
    end else begin
      lo  = (x < z) ? x : z;
      hi  = (x < z) ? z : x;
      hit = 1'b0;
      for (int i = 0; i < gates_stored && !hit; i++) begin
        if (key_lo[i] == lo && key_mid[i] == y && key_hi[i] == hi) begin
          hit    = 1'b1;
          ans.st = ST_FOUND;
          ans.id = OPERAND_BITS'(gate_id(i));
        end
      end
      if (!hit) begin
        if (gates_stored >= TABLE_CAPACITY) begin
          ans.st = ST_FULL;
          ans.id = '0;
        end else begin
          key_lo[gates_stored]  = lo;
          key_mid[gates_stored] = y;
          key_hi[gates_stored]  = hi;
          ans.st = ST_CREATED;
          ans.id = OPERAND_BITS'(gate_id(gates_stored));
          gates_stored++;
        end
      end
    end
    ans.total = TOTAL_BITS'(gates_stored);
    return ans;
  endfunction

  always @(posedge clk) begin
    gate_answer_t due;
    if (rst) begin
      gates_stored = 0;
      input_count  = '0;
      answers_due.delete();
    end else begin
      // register port: track writes, check read-back
      if (psel && penable && pready && paddr[ADDR_BITS-1:2] == REG_INPUT_COUNT) begin
        if (pwrite) begin
          input_count = pwdata[CFG_BITS-1:0];
        end else if (prdata[CFG_BITS-1:0] !== input_count) begin
          $error("prdata: expected %0d, got %0d", input_count, prdata[CFG_BITS-1:0]);
          mistakes++;
        end
      end

      // result side: compare against oldest expectation
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("result with none expected: node_id %0d status %0d gate_total %0d",
                 node_id, status, gate_total);
          mistakes++;
        end else begin
          due = answers_due.pop_front();
          if (node_id !== due.id) begin
            $error("node_id: expected %0d, got %0d", due.id, node_id);
            mistakes++;
          end
          if (status !== due.st) begin
            $error("status: expected %0d, got %0d", due.st, status);
            mistakes++;
          end
          if (gate_total !== due.total) begin
            $error("gate_total: expected %0d, got %0d", due.total, gate_total);
            mistakes++;
          end
        end
      end

      // request side: predict
      if (in_valid && !in_stall) begin
        answers_due.insert(answers_due.size(), resolve_gate(operand_a, operand_b, operand_c));
      end
    end
    pending    <= answers_due.size();
    fail_count <= mistakes;
  end

endmodule

// ===== bench/rm3_structural_hash_table_tb.sv =====
`timescale 1ns / 100ps

module rm3_structural_hash_table_tb;
  import rm3sh_pkg::*;

  localparam logic [ADDR_BITS-3:0] REG_SPARE = 1'b1;  // no register behind it
  localparam int     PHASE_ITEMS      = 410;
  localparam int     HOLD_OFF_AFTER   = 30;
  localparam int     HOLD_OFF_CYCLES  = 3000;
  localparam int     DRAIN_CYCLES     = 1100;
  localparam longint CYCLE_LIMIT      = 10_000_000;

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef enum int {STALL_NONE, STALL_SOME, STALL_MOST} stall_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_BITS-1:0]  paddr     = '0;
  logic [DATA_BITS-1:0]  pwdata    = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  operand_t              operand_a = '0;
  operand_t              operand_b = '0;
  operand_t              operand_c = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  operand_t              node_id;
  status_t               status;
  logic [TOTAL_BITS-1:0] gate_total;

  int          fail_count;
  int          pending;
  int          results_taken = 0;
  longint      cycle_count   = 0;
  logic        hold_off      = 1'b0;
  stall_mode_t stall_mode    = STALL_NONE;
  int          mode_left     = 0;
  int          burst_left    = 1;
  logic [3*OPERAND_BITS-1:0] sent_keys[$];

  always #2 clk = ~clk;

  rm3_structural_hash_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .operand_c  (operand_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .node_id    (node_id),
    .status     (status),
    .gate_total (gate_total)
  );

  rm3sh_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .operand_c  (operand_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .node_id    (node_id),
    .status     (status),
    .gate_total (gate_total),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_taken <= results_taken + 1;
  end

  // receiver stall pattern: modes of random length
  always @(posedge clk) begin
    logic busy;
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_MOST));
      mode_left  = $urandom_range(10, 300);
    end
    mode_left--;
    case (stall_mode)
      STALL_SOME: busy = ($urandom_range(0, 1) == 1);
      STALL_MOST: busy = ($urandom_range(0, 3) != 0);
      default:    busy = 1'b0;
    endcase
    out_stall <= hold_off || busy;
  end

  // one long hold-off on the result side, so the input backs up
  initial begin
    while (results_taken < HOLD_OFF_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // single APB transfer: setup, access, then idle
  task automatic reg_access(input logic write, input logic [ADDR_BITS-3:0] idx,
                            input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_input_count(input logic [CFG_BITS-1:0] value);
    reg_access(1'b1, REG_INPUT_COUNT, DATA_BITS'(value));
    reg_access(1'b0, REG_INPUT_COUNT, '0);
  endtask

  // present one request, hold until taken; gaps between bursts
  task automatic offer(input operand_t a, input operand_t b, input operand_t c);
    operand_a <= a;
    operand_b <= b;
    operand_c <= c;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      in_valid  <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(9, 1200) : $urandom_range(1, 8))
        @(posedge clk);
    end
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic operand_t pick_operand();
    if ($urandom_range(0, 15) == 0) begin
      if ($urandom_range(0, 1) == 1) return '1;
      return '0;
    end
    return operand_t'($urandom);
  endfunction

  // mostly fresh keys (fills the table), some repeats, some trivial
  task automatic random_request();
    operand_t a;
    operand_t b;
    operand_t c;
    int       roll;
    int       rule;
    a    = pick_operand();
    b    = pick_operand();
    c    = pick_operand();
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      rule = $urandom_range(0, 2);
      if (rule == 0) c = a;
      else if (rule == 1) b = a;
      else b = c;
    end else if (roll < 30 && sent_keys.size() > 0) begin
      {a, b, c} = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      if ($urandom_range(0, 1) == 1) {a, c} = {c, a};
    end else if (a != b && b != c && a != c) begin
      sent_keys.insert(sent_keys.size(), {a, b, c});
    end
    offer(a, b, c);
  endtask

  initial begin
    logic [CFG_BITS-1:0] count_plan [4];
    count_plan[0] = '1;
    count_plan[1] = CFG_BITS'($urandom_range(1, 32766));
    count_plan[2] = '0;
    count_plan[3] = CFG_BITS'($urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value, unmapped register, then the low extreme
    reg_access(1'b0, REG_INPUT_COUNT, '0);
    reg_access(1'b1, REG_SPARE, '1);
    set_input_count('0);

    // trivial rules and their priority
    offer(16'h0000, 16'h0000, 16'h0000);
    offer(16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(16'h0005, 16'hFFFF, 16'h0005);
    offer(16'h8000, 16'h8000, 16'h0003);
    offer(16'h0004, 16'h7FFF, 16'h7FFF);
    offer(16'h1234, 16'h1234, 16'h1234);
    // NOT form, then the same key with x and z swapped
    offer(16'h0000, 16'h0042, 16'h0001);
    offer(16'h0001, 16'h0042, 16'h0000);
    offer(16'h0000, 16'h0042, 16'h0001);
    offer(16'hFFFF, 16'h0000, 16'hFFFE);
    offer(16'hFFFE, 16'h0000, 16'hFFFF);
    offer(16'hAAAA, 16'h5555, 16'h0F0F);
    offer(16'h0000, 16'hFFFF, 16'h0001);
    settle();

    // high extreme offsets the ids of existing gates
    set_input_count('1);
    offer(16'h0001, 16'h0042, 16'h0000);
    offer(16'h0F0F, 16'h5555, 16'hAAAA);
    offer(16'h7FFF, 16'h8000, 16'h0001);
    offer(16'h0001, 16'h8000, 16'h7FFF);
    settle();

    // random phases; the table runs full in the last ones
    for (int phase = 0; phase < 4; phase++) begin
      set_input_count(count_plan[phase]);
      repeat (PHASE_ITEMS) random_request();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
